// ===== sv/ial_pkg.sv =====
package ial_pkg;

  // Default list capacity.
  localparam int IAL_CAPACITY = 128;

  // Operation codes.
  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_FIND   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // Request transaction payload.
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_item_t;

  // Response transaction payload.
  typedef struct packed {
    logic               ok;
    logic [6:0]         found_index;
    logic signed [31:0] read_word;
    logic [7:0]         list_count;
  } rsp_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_op;
    logic ptr_init;
    logic ptr_step;
    logic mem_rd;
    logic mem_wr;
    logic wr_item;
    logic len_clear;
    logic len_inc;
    logic len_dec;
    logic ok_set;
    logic hit_cap;
    logic word_cap;
    logic res_load;
  } ial_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       ins_ok;
    logic       pos_valid;
    logic       more;
    logic       match;
    logic       out_free;
  } ial_sts_t;

endpackage

// ===== sv/ial_ctrl.sv =====
module ial_ctrl
  import ial_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ial_sts_t sts,
  output ial_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOOP,
    S_USE,
    S_READ_ISSUE,
    S_READ_USE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_op = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.kind)
          KIND_CLEAR: begin
            cmd.len_clear = 1'b1;
            cmd.ok_set    = 1'b1;
            state_next    = S_FINISH;
          end
          KIND_INSERT: begin
            if (sts.ins_ok) begin
              cmd.ptr_init = 1'b1;
              state_next   = S_LOOP;
            end else begin
              state_next = S_FINISH;
            end
          end
          KIND_DELETE: begin
            if (sts.pos_valid) begin
              cmd.ptr_init = 1'b1;
              state_next   = S_LOOP;
            end else begin
              state_next = S_FINISH;
            end
          end
          KIND_FIND: begin
            cmd.ptr_init = 1'b1;
            state_next   = S_LOOP;
          end
          KIND_READ: begin
            if (sts.pos_valid) begin
              cmd.ptr_init = 1'b1;
              state_next   = S_READ_ISSUE;
            end else begin
              state_next = S_FINISH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      // Each step reads one entry; the next state uses the registered data.
      S_LOOP: begin
        if (sts.more) begin
          cmd.mem_rd = 1'b1;
          state_next = S_USE;
        end else begin
          case (sts.kind)
            KIND_INSERT: begin
              cmd.mem_wr  = 1'b1;
              cmd.wr_item = 1'b1;
              cmd.len_inc = 1'b1;
              cmd.ok_set  = 1'b1;
            end
            KIND_DELETE: begin
              cmd.len_dec = 1'b1;
              cmd.ok_set  = 1'b1;
            end
            default: begin
            end
          endcase
          state_next = S_FINISH;
        end
      end
      S_USE: begin
        if (sts.kind == KIND_FIND) begin
          if (sts.match) begin
            cmd.hit_cap = 1'b1;
            state_next  = S_FINISH;
          end else begin
            cmd.ptr_step = 1'b1;
            state_next   = S_LOOP;
          end
        end else begin
          cmd.mem_wr   = 1'b1;
          cmd.ptr_step = 1'b1;
          state_next   = S_LOOP;
        end
      end
      S_READ_ISSUE: begin
        cmd.mem_rd = 1'b1;
        state_next = S_READ_USE;
      end
      S_READ_USE: begin
        cmd.word_cap = 1'b1;
        cmd.ok_set   = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/ial_datapath.sv =====
module ial_datapath
  import ial_pkg::*;
#(
  parameter int CAPACITY = IAL_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req,
  input  ial_cmd_t  cmd,
  output ial_sts_t  sts,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > 8) ? LW : 8;

  // Entry memory: one write port, one registered read port.
  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // Operation registers.
  logic [2:0]  op_kind;
  logic [7:0]  op_pos;
  logic [31:0] op_value;

  logic [LW-1:0] len;
  logic [LW-1:0] ptr;
  logic [LW-1:0] ptr_dn;
  logic [LW-1:0] ptr_up;
  logic [LW-1:0] found;
  logic          ok_flag;
  logic [31:0]   word;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] ptr_ext;
  logic [CW-1:0] found_ext;
  logic [CW-1:0] ptr_up_ext;

  assign pos_ext    = CW'(op_pos);
  assign len_ext    = CW'(len);
  assign ptr_ext    = CW'(ptr);
  assign found_ext  = CW'(found);
  assign ptr_dn     = ptr - LW'(1);
  assign ptr_up     = ptr + LW'(1);
  assign ptr_up_ext = CW'(ptr_up);

  // Status towards the controller.
  always_comb begin
    sts           = '0;
    sts.kind      = op_kind;
    sts.ins_ok    = (pos_ext <= len_ext) && (len < LW'(CAPACITY));
    sts.pos_valid = (pos_ext < len_ext);
    sts.match     = (rd_data == op_value);
    sts.out_free  = !rsp_valid || rsp_ready;
    case (op_kind)
      KIND_INSERT: sts.more = (ptr_ext > pos_ext);
      KIND_DELETE: sts.more = (ptr_up_ext < len_ext);
      KIND_FIND:   sts.more = (ptr_ext < len_ext);
      default:     sts.more = 1'b0;
    endcase
  end

  // Memory addresses: shifts read the neighbour and write the current slot.
  always_comb begin
    case (op_kind)
      KIND_INSERT: rd_addr = ptr_dn[AW-1:0];
      KIND_DELETE: rd_addr = ptr_up[AW-1:0];
      default:     rd_addr = ptr[AW-1:0];
    endcase
    if (cmd.wr_item) begin
      wr_addr = pos_ext[AW-1:0];
      wr_data = op_value;
    end else begin
      wr_addr = ptr[AW-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Operation, pointer and partial result registers.
  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op_kind  <= req.kind;
      op_pos   <= req.position;
      op_value <= req.value;
      ok_flag  <= 1'b0;
      found    <= '0;
      word     <= '0;
    end
    if (cmd.ptr_init) begin
      case (op_kind)
        KIND_INSERT: ptr <= len;
        KIND_FIND:   ptr <= '0;
        default:     ptr <= pos_ext[LW-1:0];
      endcase
    end else if (cmd.ptr_step) begin
      ptr <= (op_kind == KIND_INSERT) ? ptr_dn : ptr_up;
    end
    if (cmd.ok_set || cmd.hit_cap) begin
      ok_flag <= 1'b1;
    end
    if (cmd.hit_cap) begin
      found <= ptr;
    end
    if (cmd.word_cap) begin
      word <= rd_data;
    end
  end

  // List length.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.len_clear) begin
      len <= '0;
    end else if (cmd.len_inc) begin
      len <= len + LW'(1);
    end else if (cmd.len_dec) begin
      len <= len - LW'(1);
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.ok          <= ok_flag;
      rsp.found_index <= found_ext[6:0];
      rsp.read_word   <= word;
      rsp.list_count  <= len_ext[7:0];
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(len) <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_len_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.len_inc |=> len == $past(len) + LW'(1))
    else $error("insert did not grow the list by one");

  a_shift_kind: assert property (@(posedge clk) disable iff (rst)
    (cmd.mem_wr && !cmd.wr_item) |-> (op_kind == KIND_INSERT || op_kind == KIND_DELETE))
    else $error("shift write outside insert or delete");

  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp_valid || rsp_ready))
    else $error("response register overwritten while held");
`endif

endmodule

// ===== sv/indexed_array_list_core.sv =====
// Channel | Signals                     | Payload    | Direction
// --------+-----------------------------+------------+----------
// req     | req_valid, req_ready, req   | req_item_t | in
// rsp     | rsp_valid, rsp_ready, rsp   | rsp_item_t | out
//
// Clear and rejected operations go straight from the decision to the finish state, read
// fetches one entry, insert and delete shift one entry per step, and find compares one entry
// per step until a hit or the end of the list. Each shift or compare step reads one entry
// through the single memory read port and uses the registered read data in the next state.
// Reset empties the list at once; entries are not cleared. A stalled response holds in its
// register; the next transaction is then accepted and its result waits until the register is taken.
module indexed_array_list_core
  import ial_pkg::*;
#(
  parameter int CAPACITY = IAL_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  ial_cmd_t cmd;
  ial_sts_t sts;

  // Sequencer.
  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Entry memory, length, pointer and response register.
  ial_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== sim/indexed_array_list_core_tb.sv =====
module indexed_array_list_core_tb;
  import ial_pkg::*;

  localparam int LIST_CAP = IAL_CAPACITY;

  // Operation codes that the block does not define.
  localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

  // The longest operation shifts or scans the whole list.
  localparam int DRAIN_CYCLES = 2 * LIST_CAP + 50;
  localparam int RANDOM_OPS_PER_PHASE = 100;

  // One row of the directed stimulus table.
  typedef struct packed {
    req_item_t item;
    logic      typed;
    rsp_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  // Shadow copy of the list contents and length.
  logic signed [31:0] model_words [LIST_CAP];
  int                 model_len;

  rsp_item_t expected_rsp [$];
  dir_row_t  dir_rows [$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int mismatches;
  int items_sent;
  int rsp_checked;
  int full_refusals;
  int find_hits;

  indexed_array_list_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Apply one operation to the shadow list and return the response it should give.
  function automatic rsp_item_t list_apply(input req_item_t item);
    rsp_item_t r;
    int        i;
    int        pos;
    r = '0;
    pos = int'(item.position);
    case (item.kind)
      KIND_CLEAR: begin
        model_len = 0;
        r.ok = 1'b1;
      end
      KIND_INSERT: begin
        if (model_len >= LIST_CAP) begin
          full_refusals++;
        end else if (pos <= model_len) begin
          for (i = model_len; i > pos; i--) model_words[i] = model_words[i - 1];
          model_words[pos] = item.value;
          model_len++;
          r.ok = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos < model_len) begin
          for (i = pos; i + 1 < model_len; i++) model_words[i] = model_words[i + 1];
          model_len--;
          r.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        for (i = 0; i < model_len; i++) begin
          if (model_words[i] == item.value) begin
            r.ok = 1'b1;
            r.found_index = i[6:0];
            find_hits++;
            break;
          end
        end
      end
      KIND_READ: begin
        if (pos < model_len) begin
          r.read_word = model_words[pos];
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.list_count = model_len[7:0];
    return r;
  endfunction

  // Words biased towards the extremes and small values, so that finds see duplicates.
  function automatic logic signed [31:0] random_word();
    logic signed [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 5))
        0: w = WORD_MIN;
        1: w = WORD_MAX;
        2: w = -32'sd1;
        3: w = 32'sd0;
        4: w = 32'sd1;
        default: w = 32'sd2;
      endcase
    end
    return w;
  endfunction

  // Mostly well-formed operations against the current length, with some noise.
  function automatic req_item_t random_item();
    req_item_t it;
    int        pick;
    bit        in_range;
    pick = $urandom_range(0, 99);
    in_range = ($urandom_range(0, 99) < 85);
    it.position = 8'($urandom_range(0, 255));
    it.value = random_word();
    if (pick < 3) begin
      it.kind = KIND_CLEAR;
    end else if (pick < 36) begin
      it.kind = KIND_INSERT;
      if (in_range) it.position = 8'($urandom_range(0, model_len));
    end else if (pick < 58) begin
      it.kind = KIND_DELETE;
      if (in_range)
        it.position = 8'((model_len == 0) ? 0 : $urandom_range(0, model_len - 1));
    end else if (pick < 78) begin
      it.kind = KIND_FIND;
      if (model_len > 0 && $urandom_range(0, 99) < 60)
        it.value = model_words[$urandom_range(0, model_len - 1)];
    end else if (pick < 96) begin
      it.kind = KIND_READ;
      if (in_range)
        it.position = 8'((model_len == 0) ? 0 : $urandom_range(0, model_len - 1));
    end else begin
      it.kind = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
    end
    return it;
  endfunction

  task automatic add_row(input logic [2:0] kind, input logic [7:0] pos,
                         input logic signed [31:0] val, input logic typed,
                         input logic ok, input logic [6:0] idx,
                         input logic signed [31:0] word, input logic [7:0] cnt);
    dir_row_t row;
    row.item = '{kind: kind, position: pos, value: val};
    row.typed = typed;
    row.want = '{ok: ok, found_index: idx, read_word: word, list_count: cnt};
    dir_rows.push_back(row);
  endtask

  // Offer one request transaction, with random idle cycles ahead of it.
  task automatic send_req(input req_item_t item, input logic typed, input rsp_item_t typed_rsp);
    rsp_item_t want;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = list_apply(item);
    if (typed) want = typed_rsp;
    expected_rsp.push_back(want);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding response has been taken.
  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  // Fill the list to capacity with random inserts, then knock on the full list.
  task automatic fill_list();
    req_item_t it;
    while (model_len < LIST_CAP) begin
      it.kind = KIND_INSERT;
      it.position = 8'($urandom_range(0, model_len));
      it.value = random_word();
      send_req(it, 1'b0, '0);
    end
    it.kind = KIND_INSERT;
    it.position = 8'(LIST_CAP);
    it.value = random_word();
    send_req(it, 1'b0, '0);
    it.position = 8'($urandom_range(0, LIST_CAP - 1));
    send_req(it, 1'b0, '0);
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Compare every response transaction with the oldest expectation.
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_checked++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected response: ok=%0b idx=%0d word=%0d count=%0d",
                   rsp.ok, rsp.found_index, rsp.read_word, rsp.list_count);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.ok !== want.ok || rsp.found_index !== want.found_index ||
            rsp.read_word !== want.read_word || rsp.list_count !== want.list_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected ok=%0b idx=%0d word=%0d count=%0d,",
                     want.ok, want.found_index, want.read_word, want.list_count,
                     " got ok=%0b idx=%0d word=%0d count=%0d",
                     rsp.ok, rsp.found_index, rsp.read_word, rsp.list_count);
        end
      end
    end
  end

  // Safety net in case the block stops responding.
  initial begin
    #3_000_000;
    $display("** indexed_array_list_core: FAILED **");
    $finish;
  end

  initial begin
    int        n;
    int        phase;
    rsp_item_t dummy;
    snd_idle_pct = 21;
    rcv_idle_pct = 54;
    mismatches = 0;
    items_sent = 0;
    rsp_checked = 0;
    full_refusals = 0;
    find_hits = 0;
    model_len = 0;
    for (n = 0; n < LIST_CAP; n++) model_words[n] = '0;
    dummy = '0;

    // Directed table: typed expectations where they are obvious, predictor elsewhere.
    add_row(KIND_READ,     8'd0,   32'sd0,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_DELETE,   8'd0,   32'sd0,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_FIND,     8'd0,   32'sd0,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_INSERT,   8'd1,   32'sd5,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_INSERT,   8'd0,   WORD_MAX,   1'b1, 1'b1, 7'd0, 32'sd0, 8'd1);
    add_row(KIND_INSERT,   8'd0,   WORD_MIN,   1'b1, 1'b1, 7'd0, 32'sd0, 8'd2);
    add_row(KIND_INSERT,   8'd2,   -32'sd1,    1'b1, 1'b1, 7'd0, 32'sd0, 8'd3);
    add_row(KIND_INSERT,   8'd1,   32'sd0,     1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_READ,     8'd0,   32'sd0,     1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_READ,     8'd3,   32'sd0,     1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_READ,     8'd4,   32'sd0,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_READ,     8'd255, 32'sd0,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_FIND,     8'd0,   WORD_MAX,   1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_FIND,     8'd255, -32'sd1,    1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_FIND,     8'd0,   32'sd12345, 1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_UNUSED_5, 8'd255, -32'sd1,    1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_UNUSED_6, 8'd0,   WORD_MAX,   1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_UNUSED_7, 8'd1,   WORD_MIN,   1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_INSERT,   8'd5,   32'sd7,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_DELETE,   8'd4,   32'sd0,     1'b1, 1'b0, 7'd0, 32'sd0, 8'd4);
    add_row(KIND_DELETE,   8'd0,   32'sd0,     1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_DELETE,   8'd2,   32'sd0,     1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_CLEAR,    8'd0,   32'sd0,     1'b1, 1'b1, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_FIND,     8'd0,   WORD_MAX,   1'b1, 1'b0, 7'd0, 32'sd0, 8'd0);
    add_row(KIND_INSERT,   8'd0,   32'sh55AA_55AA, 1'b0, 1'b0, 7'd0, 32'sd0, 8'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) send_req(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    drain_responses();

    // Random phases: sender idles more lightly first, then the receiver, then neither.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          snd_idle_pct = 21;
          rcv_idle_pct = 54;
        end
        1: begin
          snd_idle_pct = 54;
          rcv_idle_pct = 21;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      fill_list();
      for (n = 0; n < RANDOM_OPS_PER_PHASE; n++) send_req(random_item(), 1'b0, dummy);
      drain_responses();
    end

    // Let any late or stray response show itself before judging the run.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions and checked %0d responses, with %0d finds hitting",
             items_sent, rsp_checked, find_hits);
    $display("and %0d inserts refused on a full list; %0d mismatches.",
             full_refusals, mismatches);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("** indexed_array_list_core: PASSED **");
    end else begin
      $display("** indexed_array_list_core: FAILED **");
    end
    $finish;
  end

endmodule
